// ----- src/mncc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mncc_pkg
// Shared widths, operation codes and controller/datapath interface structs
// for the masked NCC similarity score block.
// ----------------------------------------------------------------------------
package mncc_pkg;

  localparam int PixW      = 16;
  localparam int CntW      = 17;
  localparam int SumW      = 33;
  localparam int SqW       = 49;
  localparam int ScoreW    = 16;
  localparam int MulW      = 64;
  localparam int ProdW     = 128;
  localparam int DigW      = 16;
  localparam int QuoW      = 17;
  localparam int DenW      = 82;
  localparam int DefMaxPixels = 65536;
  localparam int DefPixelBits = 16;

  // Multiplier operations, in issue order
  localparam logic [3:0] OP_NSFF = 4'd0;
  localparam logic [3:0] OP_SFSF = 4'd1;
  localparam logic [3:0] OP_NSMM = 4'd2;
  localparam logic [3:0] OP_SMSM = 4'd3;
  localparam logic [3:0] OP_NSFM = 4'd4;
  localparam logic [3:0] OP_SFSM = 4'd5;
  localparam logic [3:0] OP_DFDM = 4'd6;
  localparam logic [3:0] OP_CN1  = 4'd7;
  localparam logic [3:0] OP_NR   = 4'd8;

  localparam logic [ScoreW-1:0] ScoreHalf = 16'd32768;

  typedef struct packed {
    logic       in_ready;
    logic       acc_en;
    logic       mul_step;
    logic [1:0] dig;
    logic [3:0] op;
    logic       wb;
    logic       sqrt_step;
    logic       div_step;
    logic       out_load;
  } mncc_cmd_t;

  typedef struct packed {
    logic degenerate;
    logic out_free;
  } mncc_stat_t;

endpackage

// ----- src/mncc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mncc_ctrl
// Sequencer: accumulate beats, then walk the multiply, root and divide steps.
// ----------------------------------------------------------------------------
module mncc_ctrl import mncc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  input  mncc_stat_t stat_i,
  output mncc_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_WB   = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_LOAD = 3'd6;

  localparam logic [5:0] SqrtLast = 6'd63;
  localparam logic [5:0] DivLast  = 6'(QuoW - 1);

  logic [2:0] state_q, state_d;
  logic [3:0] op_q, op_d;
  logic [1:0] dig_q, dig_d;
  logic [5:0] it_q, it_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    dig_d   = dig_q;
    it_d    = it_q;
    cmd_o   = '0;
    cmd_o.op  = op_q;
    cmd_o.dig = dig_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc_en = 1'b1;
          if (in_last_i) begin
            state_d = ST_MUL;
            op_d    = OP_NSFF;
            dig_d   = '0;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        dig_d = dig_q + 2'd1;
        if (dig_q == 2'd3) state_d = ST_WB;
      end
      ST_WB: begin
        cmd_o.wb = 1'b1;
        priority if (op_q == OP_SMSM) begin
          state_d = ST_CHK;
        end else if (op_q == OP_DFDM) begin
          state_d = ST_SQRT;
          it_d    = '0;
        end else if (op_q == OP_NR) begin
          state_d = ST_DIV;
          it_d    = '0;
        end else begin
          state_d = ST_MUL;
          op_d    = op_q + 4'd1;
        end
      end
      ST_CHK: begin
        if (stat_i.degenerate) begin
          state_d = ST_LOAD;
        end else begin
          state_d = ST_MUL;
          op_d    = OP_NSFM;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        it_d = it_q + 6'd1;
        if (it_q == SqrtLast) begin
          state_d = ST_MUL;
          op_d    = OP_CN1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        it_d = it_q + 6'd1;
        if (it_q == DivLast) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= '0;
      dig_q   <= '0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      dig_q   <= dig_d;
      it_q    <= it_d;
    end
  end

endmodule

// ----- src/mncc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mncc_dp
// Accumulators, shared 64x16 multiplier, bit-pair square root, restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module mncc_dp import mncc_pkg::*; #(
  parameter int MAX_PIXELS = DefMaxPixels,
  parameter int PIXEL_BITS = DefPixelBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mncc_cmd_t         cmd_i,
  output mncc_stat_t        stat_o,
  input  logic [PixW-1:0]   fixed_i,
  input  logic [PixW-1:0]   moving_i,
  input  logic              mask_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ScoreW-1:0] score_o,
  output logic              flat_o,
  output logic [CntW-1:0]   used_o
);

  localparam logic [PixW-1:0] PixMask = PixW'((64'd1 << PIXEL_BITS) - 64'd1);
  localparam logic [CntW-1:0] CntMax  = CntW'(MAX_PIXELS);

  logic [CntW-1:0]  cnt_q;
  logic [SumW-1:0]  sf_q, sm_q;
  logic [SqW-1:0]   sff_q, smm_q, sfm_q;
  logic [PixW-1:0]  f, m;

  logic [MulW-1:0]  a_mux, b_mux;
  logic [DigW-1:0]  b_dig;
  logic [MulW+DigW-1:0] part;
  logic [ProdW-1:0] part_sh, prod_q, t_q, num;
  logic [MulW-1:0]  df_q, dm_q, cmag_q, root_q;
  logic             neg_q;

  logic [ProdW-1:0] sq_x_q;
  logic [MulW+1:0]  sq_rem_q, sq_r2, sq_trial;

  logic [DenW-1:0]  den_q, rem_q;
  logic [DenW:0]    dv_r2;
  logic [QuoW-1:0]  numlo_q, quo_q;

  logic             degenerate;
  logic [ScoreW-1:0] score_c;

  assign f = fixed_i & PixMask;
  assign m = moving_i & PixMask;

  // Accumulate masked-in pixels; clear when the result is loaded into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sf_q <= '0; sm_q <= '0;
      sff_q <= '0; smm_q <= '0; sfm_q <= '0;
    end else if (cmd_i.out_load) begin
      cnt_q <= '0; sf_q <= '0; sm_q <= '0;
      sff_q <= '0; smm_q <= '0; sfm_q <= '0;
    end else if (cmd_i.acc_en && mask_i && (cnt_q < CntMax)) begin
      cnt_q <= cnt_q + CntW'(1);
      sf_q  <= sf_q + SumW'(f);
      sm_q  <= sm_q + SumW'(m);
      sff_q <= sff_q + SqW'(f * f);
      smm_q <= smm_q + SqW'(m * m);
      sfm_q <= sfm_q + SqW'(f * m);
    end
  end

  // Operand selection for the shared multiplier
  always_comb begin
    unique case (cmd_i.op)
      OP_NSFF: begin a_mux = MulW'(cnt_q);  b_mux = MulW'(sff_q); end
      OP_SFSF: begin a_mux = MulW'(sf_q);   b_mux = MulW'(sf_q);  end
      OP_NSMM: begin a_mux = MulW'(cnt_q);  b_mux = MulW'(smm_q); end
      OP_SMSM: begin a_mux = MulW'(sm_q);   b_mux = MulW'(sm_q);  end
      OP_NSFM: begin a_mux = MulW'(cnt_q);  b_mux = MulW'(sfm_q); end
      OP_SFSM: begin a_mux = MulW'(sf_q);   b_mux = MulW'(sm_q);  end
      OP_DFDM: begin a_mux = df_q;          b_mux = dm_q;         end
      OP_CN1:  begin a_mux = cmag_q;        b_mux = MulW'(cnt_q - CntW'(1)); end
      OP_NR:   begin a_mux = MulW'(cnt_q);  b_mux = root_q;       end
      default: begin a_mux = '0;            b_mux = '0;           end
    endcase
  end

  assign b_dig   = b_mux[cmd_i.dig*DigW +: DigW];
  assign part    = a_mux * b_dig;
  assign part_sh = ProdW'(part) << (cmd_i.dig * DigW);
  assign num     = (t_q << 16) + prod_q;

  assign sq_r2    = {sq_rem_q[MulW-1:0], sq_x_q[ProdW-1 -: 2]};
  assign sq_trial = {root_q, 2'b01};
  assign dv_r2    = {rem_q, numlo_q[QuoW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      prod_q <= (cmd_i.dig == 2'd0) ? part_sh : prod_q + part_sh;
    end
    if (cmd_i.wb) begin
      unique case (cmd_i.op)
        OP_SFSF: df_q <= t_q[MulW-1:0] - prod_q[MulW-1:0];
        OP_SMSM: dm_q <= t_q[MulW-1:0] - prod_q[MulW-1:0];
        OP_SFSM: begin
          neg_q  <= (t_q < prod_q);
          cmag_q <= (t_q < prod_q) ? MulW'(prod_q - t_q) : MulW'(t_q - prod_q);
        end
        OP_DFDM: begin
          sq_x_q   <= prod_q;
          sq_rem_q <= '0;
          root_q   <= '0;
        end
        OP_NR: begin
          den_q   <= {prod_q[DenW-2:0], 1'b0};
          rem_q   <= num[DenW+QuoW-1:QuoW];
          numlo_q <= num[QuoW-1:0];
          quo_q   <= '0;
        end
        default: t_q <= prod_q;
      endcase
    end
    if (cmd_i.sqrt_step) begin
      sq_x_q <= sq_x_q << 2;
      if (sq_r2 >= sq_trial) begin
        sq_rem_q <= sq_r2 - sq_trial;
        root_q   <= {root_q[MulW-2:0], 1'b1};
      end else begin
        sq_rem_q <= sq_r2;
        root_q   <= {root_q[MulW-2:0], 1'b0};
      end
    end
    if (cmd_i.div_step) begin
      numlo_q <= numlo_q << 1;
      if (dv_r2 >= {1'b0, den_q}) begin
        rem_q <= DenW'(dv_r2 - {1'b0, den_q});
        quo_q <= {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_q <= dv_r2[DenW-1:0];
        quo_q <= {quo_q[QuoW-2:0], 1'b0};
      end
    end
  end

  assign degenerate = (cnt_q < CntW'(2)) || (df_q == '0) || (dm_q == '0);

  always_comb begin
    priority if (degenerate) begin
      score_c = ScoreHalf;
    end else if (neg_q) begin
      score_c = (quo_q >= QuoW'(32767)) ? '1 : ScoreW'(QuoW'(ScoreHalf) + quo_q);
    end else begin
      score_c = (quo_q >= QuoW'(ScoreHalf)) ? '0 : ScoreW'(QuoW'(ScoreHalf) - quo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      score_o <= score_c;
      flat_o  <= degenerate;
      used_o  <= cnt_q;
    end
  end

  assign stat_o.degenerate = degenerate;
  assign stat_o.out_free   = !out_valid_o || out_ready_i;

endmodule

// ----- src/masked_ncc_similarity_score.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_ncc_similarity_score
// Masked normalized cross-correlation score over one streamed image pair.
// ----------------------------------------------------------------------------
// Pixels are taken one beat per cycle while the block is accumulating. The
// beat with tlast set closes the image and starts the finish sequence, during
// which s_axis_tready is low: nine 128-bit products on one shared 64x16
// multiplier, a check step, a bit-pair square root to a 64-bit root and a
// restoring divide to a 17-bit quotient, then a load of the output register.
// An image with fewer than two masked-in pixels or a flat channel stops
// after the first four products and goes straight to the output load. The
// result register lets the next image stream in while the previous score
// still waits on the master side; only the final load waits for it to drain.
// ----------------------------------------------------------------------------
module masked_ncc_similarity_score import mncc_pkg::*; #(
  parameter int MAX_PIXELS = DefMaxPixels,
  parameter int PIXEL_BITS = DefPixelBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // fixed_pixel[15:0], moving_pixel[31:16]
  input  logic        s_axis_tuser,   // mask_on
  input  logic        s_axis_tlast,   // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // score[15:0], used_pixels[32:16], zero pad
  output logic        m_axis_tuser    // flat_image
);

  mncc_cmd_t  cmd;
  mncc_stat_t stat;
  logic [ScoreW-1:0] score;
  logic [CntW-1:0]   used;

  mncc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mncc_dp #(
    .MAX_PIXELS (MAX_PIXELS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .fixed_i     (s_axis_tdata[15:0]),
    .moving_i    (s_axis_tdata[31:16]),
    .mask_i      (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .score_o     (score),
    .flat_o      (m_axis_tuser),
    .used_o      (used)
  );

  // Ready only while accumulating
  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {7'd0, used, score};

endmodule

// ----- src/mncc_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mncc_chk
// Port-level checks for the masked NCC score block.
// ----------------------------------------------------------------------------
module mncc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A flat image always reports the neutral score
  a_flat_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] == 16'd32768)
    else $error("flat image with non-neutral score");

  // Fewer than two pixels must be flagged flat
  a_few_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[32:16] == 17'd0 || m_axis_tdata[32:16] == 17'd1)
    |-> m_axis_tuser)
    else $error("under two pixels not flagged flat");

  // Closing beat starts the finish sequence
  a_last_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("ready after closing beat");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind masked_ncc_similarity_score mncc_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- test/masked_ncc_similarity_score_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_ncc_similarity_score_tb
// Self-checking bench for the masked NCC similarity score block.
// ----------------------------------------------------------------------------
// Stream images of pixel pairs with random mask bits and gaps, predict each
// score from exact integer sums in the bench, and compare every result beat
// field by field against the oldest expected score.
// ----------------------------------------------------------------------------
module masked_ncc_similarity_score_tb;
  import mncc_pkg::*;

  localparam int MaxPix = 65536;

  typedef struct packed {
    logic [15:0] score;
    logic        flat;
    logic [16:0] used;
  } ncc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // fixed_pixel[15:0], moving_pixel[31:16]
  logic        s_axis_tuser = 1'b0; // mask_on
  logic        s_axis_tlast = 1'b0; // last_pixel
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // score[15:0], used_pixels[32:16], zero pad
  logic        m_axis_tuser;        // flat_image

  ncc_result_t score_q[$];
  int          fails = 0;
  int          images = 0;
  int          pixels = 0;
  int          flats = 0;

  // Exact running sums for the image in flight
  longint unsigned cnt, sf, sm, sff, smm, sfm;

  masked_ncc_similarity_score uut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= x) r = c;
    end
    return r;
  endfunction

  // Accumulate one pixel pair; on the closing pixel form the score and clear
  function automatic void predict_pixel(logic [15:0] f, logic [15:0] m, bit msk, bit lst);
    ncc_result_t r;
    logic [127:0] df, dm, a, b, cmag, root, nr, num, q;
    bit neg;
    if (msk && cnt < MaxPix) begin
      cnt++; sf += f; sm += m;
      sff += longint'(f) * f; smm += longint'(m) * m; sfm += longint'(f) * m;
    end
    if (!lst) return;
    r.score = ScoreHalf; r.flat = 1'b1; r.used = cnt[16:0];
    if (cnt >= 2) begin
      df = 128'(cnt) * sff - 128'(sf) * sf;
      dm = 128'(cnt) * smm - 128'(sm) * sm;
      if (df != 0 && dm != 0) begin
        a = 128'(cnt) * sfm; b = 128'(sf) * sm;
        neg = a < b;
        cmag = neg ? b - a : a - b;
        root = isqrt(df * dm);
        nr = 128'(cnt) * root;
        num = ((cmag * (cnt - 1)) << 16) + nr;
        q = num / (nr << 1);
        r.flat = 1'b0;
        if (neg) r.score = (q >= 32767) ? 16'hFFFF : 16'(32768 + q);
        else     r.score = (q >= 32768) ? 16'd0 : 16'(32768 - q);
      end
    end
    score_q.push_back(r);
    cnt = 0; sf = 0; sm = 0; sff = 0; smm = 0; sfm = 0;
  endfunction

  function automatic int gap_len();
    int p = $urandom_range(99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  bit gaps_on = 1'b1;

  // Drive one pixel beat at the falling edge and hold it until accepted;
  // valid stays high after the beat so that the next call can follow at once
  task automatic send_pixel(logic [15:0] f, logic [15:0] m, bit msk, bit lst);
    int g;
    g = gaps_on ? gap_len() : 0;
    repeat (g) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {m, f};
    s_axis_tuser  <= msk;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixel(f, m, msk, lst);
    pixels++;
    if (lst) images++;
  endtask

  // Send one image of random content with a chosen pixel value range
  task automatic send_image(int len, int lo, int hi, int mask_pct);
    for (int i = 0; i < len; i++)
      send_pixel(16'($urandom_range(hi, lo)), 16'($urandom_range(hi, lo)),
                 $urandom_range(99) < mask_pct, i == len - 1);
  endtask

  task automatic test_directed();
    // no pixels (its one pixel masked out), then a single pixel
    send_pixel(16'hFFFF, 16'h0000, 1'b0, 1'b1);
    send_pixel(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    // extremes: perfect correlation and perfect anticorrelation
    send_pixel(16'h0000, 16'h0000, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_pixel(16'h0000, 16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 1'b1, 1'b1);
    // flat fixed channel
    send_pixel(16'h1234, 16'h0001, 1'b1, 1'b0);
    send_pixel(16'h1234, 16'hABCD, 1'b1, 1'b0);
    send_pixel(16'h1234, 16'h5555, 1'b1, 1'b1);
    // flat moving channel, with a masked-out outlier that must not count
    send_pixel(16'h0001, 16'hAAAA, 1'b1, 1'b0);
    send_pixel(16'h8000, 16'h0000, 1'b0, 1'b0);
    send_pixel(16'hFFFE, 16'hAAAA, 1'b1, 1'b1);
    // mixed small image, last pixel masked out
    send_pixel(16'h00FF, 16'h7FFF, 1'b1, 1'b0);
    send_pixel(16'hFF00, 16'h8000, 1'b1, 1'b0);
    send_pixel(16'h5A5A, 16'hA5A5, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
  endtask

  task automatic test_random(int budget);
    int len;
    while (budget > 0) begin
      len = $urandom_range(12, 1);
      if (len > budget) len = budget;
      case ($urandom_range(3))
        0: send_image(len, 0, 65535, 80);
        1: send_image(len, 0, 3, 90);        // many flat and tied images
        2: send_image(len, 60000, 65535, 100);
        default: send_image(len, 0, 65535, 30);
      endcase
      budget -= len;
    end
  endtask

  // Back-to-back beats with no gaps on the input side
  task automatic test_burst();
    gaps_on = 1'b0;
    for (int k = 0; k < 6; k++) send_image($urandom_range(10, 2), 0, 65535, 85);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    gaps_on = 1'b1;
  endtask

  // Result side: random stalls, compare against the oldest expected score
  initial begin
    ncc_result_t exp_r;
    int stall;
    forever begin
      @(negedge clk_i);
      stall = gap_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (score_q.size() == 0) begin
          $error("result beat with no image pending");
          fails++;
        end else begin
          exp_r = score_q.pop_front();
          if (exp_r.flat) flats++;
          if (m_axis_tdata[15:0] !== exp_r.score) begin
            $error("score: expected %0d, got %0d", exp_r.score, m_axis_tdata[15:0]);
            fails++;
          end
          if (m_axis_tdata[32:16] !== exp_r.used) begin
            $error("used_pixels: expected %0d, got %0d", exp_r.used, m_axis_tdata[32:16]);
            fails++;
          end
          if (m_axis_tuser !== exp_r.flat) begin
            $error("flat_image: expected %0d, got %0d", exp_r.flat, m_axis_tuser);
            fails++;
          end
        end
      end
    end
  end

  initial begin
    int wait_cnt;
    cnt = 0; sf = 0; sm = 0; sff = 0; smm = 0; sfm = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_burst();
    test_random(480);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_cnt = 0;
    while (score_q.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (200) @(posedge clk_i);
    if (score_q.size() != 0) begin
      $error("%0d scores never arrived", score_q.size());
      fails++;
    end
    $display("Covered %0d pixel beats in %0d images, %0d flat or short images.",
             pixels, images, flats);
    if (fails == 0) $display("TEST PASSED");
    else            $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
